[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[sv/mds_pkg.sv]
// ----------------------------------------------------------------------------
// mds_pkg
// Shared constants and types for the duration transition scorer.
// ----------------------------------------------------------------------------
package mds_pkg;

    localparam int DUR_CATEGORIES = 8;
    localparam int DIR_CLASSES    = 8;

    localparam int CAT_W   = 3;
    localparam int COUNT_W = 16;
    localparam int SCORE_W = 16;

    localparam int DEPTH  = DUR_CATEGORIES * DIR_CLASSES * DUR_CATEGORIES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = COUNT_W + $clog2(DUR_CATEGORIES);
    localparam int DEN_W  = SUM_W + 1;
    localparam int ALU_W  = DEN_W + 1;
    localparam int COL_W  = $clog2(DUR_CATEGORIES + 1);
    localparam int STEP_W = $clog2(SCORE_W);

    localparam int Q15_MAX = 32767;

    localparam int S_TDATA_W = 32;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             carry;
    } alu_rsp_t;

endpackage

[sv/markov_duration_score.sv]
// ----------------------------------------------------------------------------
// markov_duration_score
// Transition count table with a sequenced Q1.15 scorer of (8*count - sum) / (8*count + sum).
// ----------------------------------------------------------------------------
// A write transaction stores one count and leaves the block idle. A score
// transaction streams the row out of the single table read port and
// accumulates it, forms the denominator and the magnitude, runs sixteen
// restoring divide steps, rounds, and hands the result to the output
// register, which raises m_tvalid. An empty row or a zero count skips the
// divide. A full output register that is not drained holds the block in
// the hand-off state. The row sum, denominator, magnitude, divide steps and
// rounding all go through one shared adder. The input is not ready while a
// score is in progress. The table has no reset and no clearing pass: score
// only rows fully written.
`include "assert_macros.svh"

module markov_duration_score
    import mds_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // prev_category[2:0], direction_class[5:3], next_category[8:6],
    // count_value[24:9], zero fill above
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode[0]
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // score[15:0]
    output logic [SCORE_W-1:0]   m_tdata,
    // row_empty[0]
    output logic                 m_tuser
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SUM  = 7'b0000010,
        S_NC   = 7'b0000100,
        S_MAG  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_RND  = 7'b0100000,
        S_EMIT = 7'b1000000
    } state_t;

    localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(Q15_MAX);
    localparam logic [SCORE_W-1:0] SCORE_MIN = SCORE_W'(-Q15_MAX);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [CAT_W-1:0]    col_sel_reg, col_sel_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [SCORE_W-1:0]  quo_reg, quo_next;
    logic                neg_reg, neg_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SCORE_W-1:0]  res_score_reg, res_score_next;
    logic                res_empty_reg, res_empty_next;
    logic                m_valid_reg, m_valid_next;
    logic [SCORE_W-1:0]  m_data_reg, m_data_next;
    logic                m_user_reg, m_user_next;
    logic [COUNT_W-1:0]  rd_data_reg;

    logic [COUNT_W-1:0]  table_mem [DEPTH];

    logic [CAT_W-1:0]    in_prev, in_dir, in_next;
    logic [COUNT_W-1:0]  in_count;
    logic                in_accept, idx_ok, wr_en, load_out;
    logic [ADDR_W-1:0]   in_row_base, wr_addr, rd_addr;
    logic [SUM_W-1:0]    nc;
    logic [ALU_W-1:0]    rem_dbl;
    logic [SCORE_W-1:0]  rnd_mag;
    alu_req_t            alu_req;
    alu_rsp_t            alu_rsp;

    assign in_prev  = s_tdata[CAT_W-1:0];
    assign in_dir   = s_tdata[2*CAT_W-1:CAT_W];
    assign in_next  = s_tdata[3*CAT_W-1:2*CAT_W];
    assign in_count = s_tdata[3*CAT_W+COUNT_W-1:3*CAT_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign idx_ok    = (int'(in_prev) < DUR_CATEGORIES) && (int'(in_dir) < DIR_CLASSES)
                       && (int'(in_next) < DUR_CATEGORIES);
    assign in_row_base = ADDR_W'((int'(in_prev) * DIR_CLASSES + int'(in_dir))
                                 * DUR_CATEGORIES);
    assign wr_addr  = in_row_base + ADDR_W'(in_next);
    assign wr_en    = in_accept && !s_tuser && idx_ok;
    assign rd_addr  = base_reg + ADDR_W'(col_reg);
    assign nc       = SUM_W'(int'(cnt_reg) * DUR_CATEGORIES);
    assign rem_dbl  = {rem_reg, 1'b0};
    assign rnd_mag  = alu_rsp.res[SCORE_W:1];
    assign load_out = (state_reg == S_EMIT) && (!m_valid_reg || m_tready);

    mds_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= in_count;
        end
        if ((state_reg == S_SUM) && (int'(col_reg) < DUR_CATEGORIES))
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    always_comb
    begin
        alu_req = '0;
        case (state_reg)
            S_SUM:
            begin
                alu_req.a = ALU_W'(acc_reg);
                alu_req.b = ALU_W'(rd_data_reg);
            end
            S_NC:
            begin
                alu_req.a = ALU_W'(nc);
                alu_req.b = ALU_W'(acc_reg);
            end
            S_MAG:
            begin
                alu_req.a   = neg_reg ? ALU_W'(acc_reg) : ALU_W'(nc);
                alu_req.b   = neg_reg ? ALU_W'(nc) : ALU_W'(acc_reg);
                alu_req.sub = 1'b1;
            end
            S_DIV:
            begin
                alu_req.a   = rem_dbl;
                alu_req.b   = ALU_W'(den_reg);
                alu_req.sub = 1'b1;
            end
            S_RND:
            begin
                alu_req.a = ALU_W'(quo_reg);
                alu_req.b = ALU_W'(1);
            end
            default:
            begin
                alu_req = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        col_sel_next   = col_sel_reg;
        col_next       = col_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        neg_next       = neg_reg;
        step_next      = step_reg;
        res_score_next = res_score_reg;
        res_empty_next = res_empty_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && s_tuser)
                begin
                    if (!idx_ok)
                    begin
                        res_score_next = '0;
                        res_empty_next = 1'b1;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        base_next    = in_row_base;
                        col_sel_next = in_next;
                        col_next     = '0;
                        acc_next     = '0;
                        state_next   = S_SUM;
                    end
                end
            end
            S_SUM:
            begin
                if (col_reg != '0)
                begin
                    acc_next = alu_rsp.res[SUM_W-1:0];
                    if (col_reg == COL_W'(col_sel_reg) + COL_W'(1))
                    begin
                        cnt_next = rd_data_reg;
                    end
                end
                col_next = col_reg + COL_W'(1);
                if (int'(col_reg) == DUR_CATEGORIES)
                begin
                    state_next = S_NC;
                end
            end
            S_NC:
            begin
                if (acc_reg == '0)
                begin
                    res_score_next = '0;
                    res_empty_next = 1'b1;
                    state_next     = S_EMIT;
                end
                else if (cnt_reg == '0)
                begin
                    res_score_next = SCORE_MIN;
                    res_empty_next = 1'b0;
                    state_next     = S_EMIT;
                end
                else
                begin
                    den_next   = alu_rsp.res[DEN_W-1:0];
                    neg_next   = (nc < acc_reg);
                    state_next = S_MAG;
                end
            end
            S_MAG:
            begin
                rem_next   = alu_rsp.res[DEN_W-1:0];
                quo_next   = '0;
                step_next  = STEP_W'(SCORE_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!alu_rsp.carry)
                begin
                    rem_next = alu_rsp.res[DEN_W-1:0];
                    quo_next = {quo_reg[SCORE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_dbl[DEN_W-1:0];
                    quo_next = {quo_reg[SCORE_W-2:0], 1'b0};
                end
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = S_RND;
                end
            end
            S_RND:
            begin
                if (alu_rsp.res[SCORE_W])
                begin
                    res_score_next = neg_reg ? SCORE_MIN : SCORE_MAX;
                end
                else
                begin
                    res_score_next = neg_reg ? (SCORE_W'(0) - rnd_mag) : rnd_mag;
                end
                res_empty_next = 1'b0;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (load_out)
        begin
            m_valid_next = 1'b1;
            m_data_next  = res_score_reg;
            m_user_next  = res_empty_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg      <= base_next;
        col_sel_reg   <= col_sel_next;
        col_reg       <= col_next;
        acc_reg       <= acc_next;
        cnt_reg       <= cnt_next;
        den_reg       <= den_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        neg_reg       <= neg_next;
        step_reg      <= step_next;
        res_score_reg <= res_score_next;
        res_empty_reg <= res_empty_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `ASSERT_PROP(a_div_rem_below_den, clk, rst_n, (state_reg == S_DIV) |-> (rem_reg < den_reg))
    `ASSERT_PROP(a_sum_covers_count, clk, rst_n, (state_reg == S_NC) |-> (acc_reg >= cnt_reg))
    `ASSERT_PROP(a_empty_scores_zero, clk, rst_n, (m_tvalid && m_tuser) |-> (m_tdata == '0))
    `ASSERT_NEVER(a_no_most_negative, clk, rst_n, m_tvalid && (m_tdata == {1'b1, {(SCORE_W-1){1'b0}}}))

endmodule

[sv/mds_alu.sv]
// ----------------------------------------------------------------------------
// mds_alu
// Shared add/subtract unit; carry out doubles as borrow on subtract.
// ----------------------------------------------------------------------------
module mds_alu
    import mds_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ALU_W:0] full;

    always_comb
    begin
        if (req.sub)
        begin
            full = {1'b0, req.a} - {1'b0, req.b};
        end
        else
        begin
            full = {1'b0, req.a} + {1'b0, req.b};
        end
    end

    assign rsp.res   = full[ALU_W-1:0];
    assign rsp.carry = full[ALU_W];

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the duration transition scorer: count writes build
// rows of the table, score transactions are predicted from a local copy of
// the table and compared field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb;
    import mds_pkg::*;

    localparam int ROWS        = DUR_CATEGORIES * DIR_CLASSES;
    localparam int STUCK_LIMIT = 2000;
    localparam int TAIL_CYCLES = 64;
    localparam int RANDOM_ITEMS = 750;
    localparam int HOLD_EVERY  = 200;

    typedef enum bit {OP_WRITE = 1'b0, OP_SCORE = 1'b1} op_e;

    typedef struct {
        op_e                op;
        logic [CAT_W-1:0]   prev_cat;
        logic [CAT_W-1:0]   dir_cls;
        logic [CAT_W-1:0]   next_cat;
        logic [COUNT_W-1:0] count;
        bit                 drain;
    } cmd_t;

    typedef struct {
        logic [SCORE_W-1:0] score;
        logic               row_empty;
    } verdict_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [SCORE_W-1:0]   m_tdata;
    logic                 m_tuser;

    cmd_t               cmd_q[$];
    cmd_t               on_bus;
    verdict_t           due_scores[$];
    logic [COUNT_W-1:0] tally[DEPTH];
    bit                 written[DEPTH];
    bit                 row_ready[ROWS];
    int                 ready_rows[$];
    int                 errors = 0;
    int                 n_taken = 0;
    int                 stuck = 0;
    bit                 calm;

    markov_duration_score dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    assign calm = (n_taken >= 300) && (n_taken < 420);

    task automatic flag_mismatch(input string msg);
        $display("%0t: MISMATCH %s", $time, msg);
        errors++;
    endtask

    function automatic void add_cmd(input op_e op, input int row, input int col,
                                    input int cnt, input bit drain);
        cmd_t c;
        int   base;
        int   k;
        bit   full;
        c.op       = op;
        c.prev_cat = CAT_W'(row / DIR_CLASSES);
        c.dir_cls  = CAT_W'(row % DIR_CLASSES);
        c.next_cat = CAT_W'(col);
        c.count    = COUNT_W'(cnt);
        c.drain    = drain;
        cmd_q.push_back(c);
        if (op == OP_WRITE)
        begin
            base = row * DUR_CATEGORIES;
            written[base + col] = 1'b1;
            full = 1'b1;
            for (k = 0; k < DUR_CATEGORIES; k++)
                full &= written[base + k];
            if (full && !row_ready[row])
            begin
                row_ready[row] = 1'b1;
                ready_rows.push_back(row);
            end
        end
    endfunction

    function automatic int pick_count(input int style);
        int roll;
        roll = $urandom_range(0, 99);
        case (style)
            0: return 0;
            1: return (roll < 70) ? 0 : $urandom_range(0, 65535);
            default:
            begin
                if (roll < 15)
                    return 0;
                else if (roll < 30)
                    return 65535;
                else if (roll < 50)
                    return $urandom_range(1, 15);
                else
                    return $urandom_range(0, 65535);
            end
        endcase
    endfunction

    // fold one accepted transaction into the table, queue the score it owes
    task automatic forecast_score(input cmd_t c);
        int                base;
        int                k;
        longint unsigned   total;
        longint unsigned   nc;
        longint unsigned   den;
        longint unsigned   mag;
        longint unsigned   q;
        bit                neg;
        logic [COUNT_W-1:0] hit;
        verdict_t          v;
        base = (int'(c.prev_cat) * DIR_CLASSES + int'(c.dir_cls)) * DUR_CATEGORIES;
        if (c.op == OP_WRITE)
            tally[base + int'(c.next_cat)] = c.count;
        else
        begin
            total = 0;
            for (k = 0; k < DUR_CATEGORIES; k++)
                total += tally[base + k];
            hit = tally[base + int'(c.next_cat)];
            v.row_empty = 1'b0;
            if (total == 0)
            begin
                v.score     = '0;
                v.row_empty = 1'b1;
            end
            else if (hit == 0)
                v.score = SCORE_W'(-Q15_MAX);
            else
            begin
                nc  = longint'(DUR_CATEGORIES) * hit;
                den = nc + total;
                neg = nc < total;
                mag = neg ? total - nc : nc - total;
                q   = (2 * mag * 32768 + den) / (2 * den);
                if (q > Q15_MAX)
                    q = Q15_MAX;
                v.score = q[SCORE_W-1:0];
                if (neg)
                    v.score = -v.score;
            end
            due_scores.push_back(v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                forecast_score(on_bus);
                n_taken <= n_taken + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (cmd_q.size() != 0 && !(cmd_q[0].drain && due_scores.size() != 0)
                    && (calm || $urandom_range(0, 99) >= 29))
                begin
                    on_bus = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_W - COUNT_W - 3 * CAT_W){1'b0}}, on_bus.count,
                                 on_bus.next_cat, on_bus.dir_cls, on_bus.prev_cat};
                    s_tuser  <= on_bus.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_scores.size() == 0)
                    flag_mismatch($sformatf("unexpected result score=%0d row_empty=%0b",
                                            $signed(m_tdata), m_tuser));
                else
                begin
                    if (m_tdata !== due_scores[0].score)
                        flag_mismatch($sformatf("score got %0d want %0d",
                                                $signed(m_tdata),
                                                $signed(due_scores[0].score)));
                    if (m_tuser !== due_scores[0].row_empty)
                        flag_mismatch($sformatf("row_empty got %0b want %0b",
                                                m_tuser, due_scores[0].row_empty));
                    void'(due_scores.pop_front());
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 29);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck <= 0;
            else
                stuck <= stuck + 1;
            if (stuck >= STUCK_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        int k;
        int n;
        int row;
        int roll;
        int style;
        int next_hold;
        bit hold;

        // empty row, then a lone count, a zero count and a minimal count
        for (k = 0; k < DUR_CATEGORIES; k++)
            add_cmd(OP_WRITE, 0, k, 0, 1'b0);
        add_cmd(OP_SCORE, 0, 0, 0, 1'b0);
        add_cmd(OP_WRITE, 0, 7, 65535, 1'b0);
        add_cmd(OP_SCORE, 0, 7, 0, 1'b0);
        add_cmd(OP_SCORE, 0, 0, 0, 1'b0);
        add_cmd(OP_WRITE, 0, 0, 1, 1'b0);
        add_cmd(OP_SCORE, 0, 0, 65535, 1'b0);
        // full row of maximum counts gives a neutral score
        for (k = 0; k < DUR_CATEGORIES; k++)
            add_cmd(OP_WRITE, ROWS - 1, k, 65535, 1'b0);
        add_cmd(OP_SCORE, ROWS - 1, 7, 0, 1'b1);
        add_cmd(OP_SCORE, ROWS - 1, 2, 65535, 1'b0);

        n = 0;
        next_hold = HOLD_EVERY;
        hold = 1'b1;
        while (n < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50 && ready_rows.size() != 0)
            begin
                row = ready_rows[$urandom_range(0, ready_rows.size() - 1)];
                add_cmd(OP_SCORE, row, $urandom_range(0, 7), $urandom_range(0, 65535), hold);
                n++;
            end
            else if (roll < 62)
            begin
                row = $urandom_range(0, ROWS - 1);
                roll = $urandom_range(0, 9);
                style = (roll < 2) ? 0 : ((roll < 5) ? 1 : 2);
                for (k = 0; k < DUR_CATEGORIES; k++)
                    add_cmd(OP_WRITE, row, k, pick_count(style), hold && (k == 0));
                n += DUR_CATEGORIES;
            end
            else
            begin
                add_cmd(OP_WRITE, $urandom_range(0, ROWS - 1), $urandom_range(0, 7),
                        pick_count(2), hold);
                n++;
            end
            hold = 1'b0;
            if (n >= next_hold)
            begin
                hold = 1'b1;
                next_hold += HOLD_EVERY;
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (cmd_q.size() != 0 || s_tvalid || due_scores.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (due_scores.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", due_scores.size()));
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[markov_duration_score.f]
+incdir+sv
sv/mds_pkg.sv
sv/mds_alu.sv
sv/markov_duration_score.sv
verif/tb.sv
